// File: hdl/mexp_pkg.sv
// Package with the shared default width and the controller state type for modular exponentiation.
package mexp_pkg;

  localparam int unsigned WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_t;

endpackage

// File: hdl/modular_exponentiation.sv
// Top level: bit-serial right-to-left square-and-multiply modular exponentiation.
//
// The modulus is written through cfg_wr_en and cfg_wr_data. The user must write it
// only while the block is idle; the block itself does not enforce this. The modulus
// resets to one. Each input item carries a base and an exponent and yields one output
// item holding base to the power exponent, reduced modulo the modulus.
// A modulus of zero gives a result of zero.
// An item first reduces the base modulo the modulus, one base bit per cycle.
// Then each exponent bit up to the highest set bit passes a check state, then a
// multiply when the bit is set, then a squaring. Each multiply or squaring cycle
// doubles the partial product and adds the multiplicand when the current multiplier
// bit is set, with both steps reduced by the modulus.
// One item is in work at a time. in_ready is high while the controller is idle, so
// the next item can be accepted at the edge after the previous result appears.
// The finished result sits in an output register until it is taken, and a new
// item may be accepted meanwhile. A stalled receiver holds the next result in the
// final state until the output register is free.
// Reset returns the controller to idle, empties the output and sets the modulus to one.
module modular_exponentiation #(
  parameter int unsigned WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [WIDTH-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_base_value,
  input  logic [WIDTH-1:0] in_exponent_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_power_result
);

  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  mexp_pkg::state_t state_r, state_nxt;

  logic [WIDTH-1:0] modulus_r;
  logic [WIDTH-1:0] mod_r, mod_nxt;
  logic [WIDTH-1:0] exp_r, exp_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] pow_r, pow_nxt;
  logic [WIDTH-1:0] prod_r, prod_nxt;
  logic [WIDTH-1:0] shreg_r, shreg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_data_r, out_data_nxt;

  logic [WIDTH:0]   dbl_sum;
  logic [WIDTH-1:0] dbl_red;
  logic [WIDTH:0]   add_sum;
  logic [WIDTH-1:0] add_red;
  logic             in_bit;
  logic             add_en;

  // One step of the serial datapath: double with an optional input bit, reduce,
  // then add the multiplicand when the current multiplier bit is set, and reduce.
  always_comb begin
    in_bit  = (state_r == mexp_pkg::ST_REDUCE) && shreg_r[WIDTH-1];
    add_en  = (state_r != mexp_pkg::ST_REDUCE) && shreg_r[WIDTH-1];
    dbl_sum = {prod_r, in_bit};
    if (dbl_sum >= {1'b0, mod_r}) begin
      dbl_red = WIDTH'(dbl_sum - {1'b0, mod_r});
    end else begin
      dbl_red = dbl_sum[WIDTH-1:0];
    end
    add_sum = {1'b0, dbl_red} + (add_en ? {1'b0, pow_r} : {(WIDTH + 1){1'b0}});
    if (add_sum >= {1'b0, mod_r}) begin
      add_red = WIDTH'(add_sum - {1'b0, mod_r});
    end else begin
      add_red = add_sum[WIDTH-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = mod_r;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    pow_nxt       = pow_r;
    prod_nxt      = prod_r;
    shreg_nxt     = shreg_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = (state_r == mexp_pkg::ST_IDLE);

    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_valid) begin
          mod_nxt   = modulus_r;
          exp_nxt   = in_exponent_value;
          shreg_nxt = in_base_value;
          prod_nxt  = '0;
          cnt_nxt   = CNT_LAST;
          if (modulus_r == '0) begin
            acc_nxt   = '0;
            state_nxt = mexp_pkg::ST_DONE;
          end else begin
            state_nxt = mexp_pkg::ST_REDUCE;
          end
        end
      end
      mexp_pkg::ST_REDUCE: begin
        prod_nxt  = add_red;
        shreg_nxt = {shreg_r[WIDTH-2:0], 1'b0};
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          pow_nxt   = add_red;
          acc_nxt   = (mod_r == WIDTH'(1)) ? '0 : WIDTH'(1);
          state_nxt = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_CHECK: begin
        prod_nxt = '0;
        cnt_nxt  = CNT_LAST;
        if (exp_r == '0) begin
          state_nxt = mexp_pkg::ST_DONE;
        end else if (exp_r[0]) begin
          shreg_nxt = acc_r;
          state_nxt = mexp_pkg::ST_MUL;
        end else begin
          shreg_nxt = pow_r;
          state_nxt = mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_MUL: begin
        prod_nxt  = add_red;
        shreg_nxt = {shreg_r[WIDTH-2:0], 1'b0};
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          acc_nxt   = add_red;
          prod_nxt  = '0;
          shreg_nxt = pow_r;
          cnt_nxt   = CNT_LAST;
          state_nxt = mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_SQR: begin
        prod_nxt  = add_red;
        shreg_nxt = {shreg_r[WIDTH-2:0], 1'b0};
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          pow_nxt   = add_red;
          exp_nxt   = {1'b0, exp_r[WIDTH-1:1]};
          state_nxt = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
          state_nxt     = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= WIDTH'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        modulus_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    mod_r      <= mod_nxt;
    exp_r      <= exp_nxt;
    acc_r      <= acc_nxt;
    pow_r      <= pow_nxt;
    prod_r     <= prod_nxt;
    shreg_r    <= shreg_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_power_result = out_data_r;

endmodule
